@@ sv/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    localparam int MODE_W = 3;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CNT_W  = 8;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam int DEF_MAX_COLS = 80;
    localparam int DEF_MAX_ROWS = 25;
    localparam int DEF_DEPTH    = DEF_MAX_COLS * DEF_MAX_ROWS;
    localparam int DEF_ADDR_W   = (DEF_DEPTH > 1) ? $clog2(DEF_DEPTH) : 1;
    localparam int DEF_IDX_W    = $clog2(DEF_DEPTH + 1);

    // APB register file
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROWS    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLOR   = 2'd2;

    localparam logic [COL_W-1:0]  RST_COLUMNS = 7'd80;
    localparam logic [ROW_W-1:0]  RST_ROWS    = 5'd25;
    localparam logic [ATTR_W-1:0] RST_COLOR   = 8'h0F;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT_CUR = 3'd0,
        MODE_PUT_AT  = 3'd1,
        MODE_SET_CUR = 3'd2,
        MODE_CLEAR   = 3'd3,
        MODE_SCR_UP  = 3'd4,
        MODE_SCR_DN  = 3'd5,
        MODE_READ    = 3'd6,
        MODE_NOP     = 3'd7
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CNT_W-1:0]  count;
    } t_req;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } t_rsp;

    // operands of the shared index unit: y = col + columns * row
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_mac_req;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_PUTC,
        S_PUT1,
        S_RC_ADDR,
        S_RC_RD,
        S_RC_WR,
        S_RD,
        S_RD_CAP,
        S_CLR_START,
        S_CLR,
        S_SCR_START,
        S_SCR_TOT,
        S_SCR_LOAD,
        S_SCR_CHK,
        S_SCR_WR,
        S_FIN,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

@@ sv/text_console_writer.sv @@
// Put at cursor scrolls up by one line when it leaves the bottom row. Clear blanks
// columns*rows cells and homes the cursor; scroll reads then writes each moved cell and
// writes a blank into each freed cell.
// One request at a time; the next is taken the cycle after the result is registered.
// Reset: cursor 0,0, registers 80/25/0x0F, then a zeroing sweep over all MAX_COLS*MAX_ROWS cells.
`default_nettype none

module text_console_writer #(
    parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_req_valid,
    output logic                         o_req_stall,
    input  tcw_pkg::t_req                i_req,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_stall,
    output tcw_pkg::t_rsp                o_rsp
);
    import tcw_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = $clog2(DEPTH + 1);

    // configuration
    logic [COL_W-1:0]     r_columns;
    logic [ROW_W-1:0]     r_rows;
    logic [ATTR_W-1:0]    r_color;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // sequencer
    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    logic [CHAR_W-1:0] r_ch, n_ch;
    logic [COL_W-1:0]  r_pc, n_pc;
    logic [ROW_W-1:0]  r_pr, n_pr;
    logic [ROW_W-1:0]  r_k, n_k;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_end, n_end;
    logic [IDX_W-1:0]  r_off, n_off;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [CELL_W-1:0] r_data, n_data;
    logic              r_rsp_valid, n_rsp_valid;
    t_rsp              r_rsp, n_rsp;

    // geometry and helpers
    logic [COL_W-1:0]  nc, nc_m1;
    logic [ROW_W-1:0]  nr, nr_m1;
    logic [COL_W:0]    col_inc;
    logic              col_wrap;
    logic              row_last;
    logic [IDX_W:0]    src_up;
    logic              src_up_ok;
    logic [IDX_W-1:0]  dn_dst;
    logic              src_dn_ok;
    logic [IDX_W-1:0]  src_dn;
    logic              scr_up;
    logic [CELL_W-1:0] blank;
    logic              rsp_free;

    // shared index unit and cell store
    t_mac_req          mac_req;
    logic [IDX_W-1:0]  mac_y;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcw_mac #(
        .IDX_W (IDX_W)
    ) u_mac (
        .i_clk (i_clk),
        .i_req (mac_req),
        .i_nc  (nc),
        .o_y   (mac_y)
    );

    tcw_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- APB register file ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= RST_COLUMNS;
            r_rows    <= RST_ROWS;
            r_color   <= RST_COLOR;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_COLUMNS: r_columns <= pwdata[COL_W-1:0];
                REG_ROWS:    r_rows    <= pwdata[ROW_W-1:0];
                REG_COLOR:   r_color   <= pwdata[ATTR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_COLUMNS: prdata = {{(PDATA_W - COL_W){1'b0}}, r_columns};
            REG_ROWS:    prdata = {{(PDATA_W - ROW_W){1'b0}}, r_rows};
            REG_COLOR:   prdata = {{(PDATA_W - ATTR_W){1'b0}}, r_color};
            default:     prdata = '0;
        endcase
    end

    // ---------------- geometry ----------------
    always_comb begin
        nc = r_columns;
        if (r_columns == '0) begin
            nc = COL_W'(1);
        end else if (int'(r_columns) > MAX_COLS) begin
            nc = COL_W'(MAX_COLS);
        end
        nr = r_rows;
        if (r_rows == '0) begin
            nr = ROW_W'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            nr = ROW_W'(MAX_ROWS);
        end
    end

    assign nc_m1    = nc - COL_W'(1);
    assign nr_m1    = nr - ROW_W'(1);
    assign col_inc  = {1'b0, r_cur_col} + (COL_W + 1)'(1);
    assign col_wrap = (col_inc >= {1'b0, nc});
    assign row_last = (r_cur_row >= nr_m1);
    assign blank    = {r_color, BLANK_CODE};
    assign rsp_free = !r_rsp_valid || !i_rsp_stall;

    assign scr_up    = (r_mode != MODE_SCR_DN);
    assign src_up    = {1'b0, r_idx} + {1'b0, r_off};
    assign src_up_ok = (src_up < {1'b0, r_end});
    assign dn_dst    = r_idx - IDX_W'(1);
    assign src_dn_ok = (dn_dst >= r_off);
    assign src_dn    = dn_dst - r_off;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_ch        = r_ch;
        n_pc        = r_pc;
        n_pr        = r_pr;
        n_k         = r_k;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_idx       = r_idx;
        n_end       = r_end;
        n_off       = r_off;
        n_addr      = r_addr;
        n_data      = r_data;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end

        mac_req   = '{col: r_cur_col, row: r_cur_row};
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = blank;
        ram_raddr = r_idx;

        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_idx == IDX_W'(DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_mode    = t_mode'(i_req.mode);
                    n_ch      = i_req.char_code;
                    n_pc      = (i_req.col > nc_m1) ? nc_m1 : i_req.col;
                    n_pr      = (i_req.row > nr_m1) ? nr_m1 : i_req.row;
                    n_k       = (i_req.count > {{(CNT_W - ROW_W){1'b0}}, nr}) ?
                                nr : i_req.count[ROW_W-1:0];
                    n_cur_col = (r_cur_col > nc_m1) ? nc_m1 : r_cur_col;
                    n_cur_row = (r_cur_row > nr_m1) ? nr_m1 : r_cur_row;
                    n_data    = '0;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_mode)
                    MODE_PUT_CUR: begin
                        if (r_ch == NEWLINE_CODE) begin
                            n_cur_col = '0;
                            if (row_last) begin
                                n_k     = ROW_W'(1);
                                n_state = S_SCR_START;
                            end else begin
                                n_cur_row = r_cur_row + ROW_W'(1);
                                n_state   = S_RC_ADDR;
                            end
                        end else begin
                            n_state = S_PUTC;
                        end
                    end
                    MODE_PUT_AT: begin
                        mac_req = '{col: r_pc, row: r_pr};
                        n_state = S_PUT1;
                    end
                    MODE_SET_CUR: begin
                        n_cur_col = r_pc;
                        n_cur_row = r_pr;
                        n_state   = S_RC_ADDR;
                    end
                    MODE_CLEAR: begin
                        mac_req = '{col: '0, row: nr};
                        n_state = S_CLR_START;
                    end
                    MODE_SCR_UP, MODE_SCR_DN: begin
                        n_state = S_SCR_START;
                    end
                    MODE_READ: begin
                        mac_req = '{col: r_pc, row: r_pr};
                        n_state = S_RD;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_PUTC: begin
                ram_we    = 1'b1;
                ram_waddr = mac_y;
                ram_wdata = {r_color, r_ch};
                if (col_wrap) begin
                    n_cur_col = '0;
                    if (row_last) begin
                        n_k     = ROW_W'(1);
                        n_state = S_SCR_START;
                    end else begin
                        n_cur_row = r_cur_row + ROW_W'(1);
                        n_state   = S_RC_ADDR;
                    end
                end else begin
                    n_cur_col = col_inc[COL_W-1:0];
                    n_state   = S_RC_ADDR;
                end
            end
            S_PUT1: begin
                ram_we    = 1'b1;
                ram_waddr = mac_y;
                ram_wdata = {r_color, r_ch};
                n_state   = S_FIN;
            end
            S_RC_ADDR: begin
                n_state = S_RC_RD;
            end
            S_RC_RD: begin
                ram_raddr = mac_y;
                n_addr    = mac_y;
                n_state   = S_RC_WR;
            end
            S_RC_WR: begin
                // keep the character, take the current attribute
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = {r_color, ram_rdata[CHAR_W-1:0]};
                n_state   = S_FIN;
            end
            S_RD: begin
                ram_raddr = mac_y;
                n_state   = S_RD_CAP;
            end
            S_RD_CAP: begin
                n_data  = ram_rdata;
                n_state = S_FIN;
            end
            S_CLR_START: begin
                n_end   = mac_y;
                n_idx   = '0;
                n_state = S_CLR;
            end
            S_CLR: begin
                if (r_idx == r_end) begin
                    n_cur_col = '0;
                    n_cur_row = '0;
                    n_state   = S_FIN;
                end else begin
                    ram_we = 1'b1;
                    n_idx  = r_idx + IDX_W'(1);
                end
            end
            S_SCR_START: begin
                mac_req = '{col: '0, row: r_k};
                n_state = S_SCR_TOT;
            end
            S_SCR_TOT: begin
                n_off   = mac_y;
                mac_req = '{col: '0, row: nr};
                n_state = S_SCR_LOAD;
            end
            S_SCR_LOAD: begin
                n_end   = mac_y;
                n_idx   = scr_up ? '0 : mac_y;
                n_state = S_SCR_CHK;
            end
            S_SCR_CHK: begin
                // up walks forward, down walks backward, so sources are read before overwrite
                if (scr_up) begin
                    if (r_idx == r_end) begin
                        n_state = (r_mode == MODE_PUT_CUR) ? S_RC_ADDR : S_FIN;
                    end else if (src_up_ok) begin
                        ram_raddr = src_up[IDX_W-1:0];
                        n_state   = S_SCR_WR;
                    end else begin
                        ram_we = 1'b1;
                        n_idx  = r_idx + IDX_W'(1);
                    end
                end else begin
                    if (r_idx == '0) begin
                        n_state = S_FIN;
                    end else if (src_dn_ok) begin
                        ram_raddr = src_dn;
                        n_state   = S_SCR_WR;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = dn_dst;
                        n_idx     = dn_dst;
                    end
                end
            end
            S_SCR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (scr_up) begin
                    n_idx = r_idx + IDX_W'(1);
                end else begin
                    ram_waddr = dn_dst;
                    n_idx     = dn_dst;
                end
                n_state = S_SCR_CHK;
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (rsp_free) begin
                    n_rsp_valid      = 1'b1;
                    n_rsp.cursor_col = r_cur_col;
                    n_rsp.cursor_row = r_cur_row;
                    n_rsp.cursor_pos = POS_W'(mac_y);
                    n_rsp.cell_data  = r_data;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_ch   <= n_ch;
        r_pc   <= n_pc;
        r_pr   <= n_pr;
        r_k    <= n_k;
        r_end  <= n_end;
        r_off  <= n_off;
        r_addr <= n_addr;
        r_data <= n_data;
        r_rsp  <= n_rsp;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // ---------------- assertions ----------------
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> (r_state == S_DECODE))
        else $error("accepted request did not enter decode");

    a_data_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_mode != MODE_READ) |-> (r_data == '0))
        else $error("cell data set outside a read");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCR_CHK || r_state == S_CLR) |-> (r_idx <= r_end))
        else $error("clear or scroll index past the active area");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("cell store written while idle");

endmodule

`default_nettype wire

@@ sv/tcw_mac.sv @@
`default_nettype none

module tcw_mac #(
    parameter int IDX_W = tcw_pkg::DEF_IDX_W
) (
    input  logic                       i_clk,
    input  tcw_pkg::t_mac_req          i_req,
    input  logic [tcw_pkg::COL_W-1:0]  i_nc,
    output logic [IDX_W-1:0]           o_y
);
    import tcw_pkg::*;

    logic [COL_W+ROW_W-1:0] prod;
    logic [COL_W+ROW_W:0]   sum;
    logic [IDX_W-1:0]       r_y;

    assign prod = {{ROW_W{1'b0}}, i_nc} * {{COL_W{1'b0}}, i_req.row};
    assign sum  = {1'b0, prod} + {{(ROW_W + 1){1'b0}}, i_req.col};

    always_ff @(posedge i_clk) begin
        r_y <= IDX_W'(sum);
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

@@ sv/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_DEPTH,
    parameter int ADDR_W = tcw_pkg::DEF_ADDR_W
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
